/* rtl/core/rcfp_pkg.sv */
package rcfp_pkg;

    // frame geometry
    localparam int CHANNEL_COUNT = 16;
    localparam int CHANNEL_BITS  = 11;

    // input and scaling widths
    localparam int IN_W        = 12;
    localparam int MID_VALUE   = 992;
    localparam int SAT_LIMIT   = ((2 * MID_VALUE) < ((1 << CHANNEL_BITS) - 1)) ?
                                 (2 * MID_VALUE) : ((1 << CHANNEL_BITS) - 1);
    localparam int RECIP_MUL   = 52429;     // ceil(2^18 / 5)
    localparam int RECIP_SHIFT = 18;
    localparam int MAG4_W      = IN_W + 2;
    localparam int MUL_W       = MAG4_W + 16;
    localparam int QUOT_W      = 11;
    localparam int SUM_W       = 13;

    // packing
    localparam int DATA_BYTES = (CHANNEL_COUNT * CHANNEL_BITS + 7) / 8;
    localparam int ACC_W      = CHANNEL_BITS + 7;
    localparam int HELD_W     = $clog2(CHANNEL_BITS + 8);
    localparam int CNT_W      = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam logic [7:0] LEN_BASE = 8'((2 + DATA_BYTES) % 256);

    // configuration register indexes
    localparam logic [1:0] CFG_SWITCH_ARMING  = 2'd0;
    localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd1;
    localparam logic [1:0] CFG_FRAME_TYPE     = 2'd2;
    localparam logic [1:0] CFG_CRC_POLYNOMIAL = 2'd3;

    // crc-8, msb first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ poly) : (c << 1);
        end
        return c;
    endfunction

endpackage

/* rtl/core/rcfp_scale.sv */
module rcfp_scale
    import rcfp_pkg::*;
(
    input  logic signed [IN_W-1:0]   channel_value,
    output logic [CHANNEL_BITS-1:0]  scaled
);

    logic                     neg;
    logic [IN_W-1:0]          mag;
    logic [MUL_W-1:0]         prod;
    logic [QUOT_W-1:0]        quot;
    logic signed [SUM_W-1:0]  sum;
    logic [SUM_W-2:0]         sat;

    // |4v| / 5 by reciprocal multiply, exact over the input range
    always_comb begin
        neg  = channel_value[IN_W-1];
        mag  = neg ? IN_W'(-channel_value) : IN_W'(channel_value);
        prod = MUL_W'({mag, 2'b00}) * MUL_W'(RECIP_MUL);
        quot = prod[RECIP_SHIFT +: QUOT_W];
        sum  = neg ? (SUM_W'(MID_VALUE) - SUM_W'(quot))
                   : (SUM_W'(MID_VALUE) + SUM_W'(quot));
        if (sum < 0) begin
            sat = '0;
        end else if (sum > $signed(SUM_W'(SAT_LIMIT))) begin
            sat = (SUM_W-1)'(SAT_LIMIT);
        end else begin
            sat = sum[SUM_W-2:0];
        end
        scaled = CHANNEL_BITS'(sat);
    end

endmodule

/* rtl/core/rc_channel_frame_packer.sv */
// Packs one signed rc channel per input transfer into a serial frame: the value is scaled
// by 4/5 (truncating toward zero), centered on 992, saturated to 0..1984 and appended
// lsb-first as an 11-bit field. The first channel of a frame is preceded by the address,
// length and type bytes; the last one is followed by any zero-padded partial byte, an
// armed byte of 1 when switch_arming is set, and a crc-8 over the type through armed bytes.
// Bytes leave one per cycle, when m_ready does not stall the output, through a single
// output register; an item causes 1 or 2 bytes for middle channels and up to 4 for the
// first and last channel, with the next item taken in the cycle its predecessor's last
// byte is sent. Input holds one registered item ahead of the byte sequencer.
// Configuration writes take effect at the next clock edge.
module rc_channel_frame_packer
    import rcfp_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    cfg_wr_en,
    input  logic [1:0]              cfg_addr,
    input  logic [7:0]              cfg_data,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [IN_W-1:0]  s_channel_value,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [7:0]              m_out_byte,
    output logic                    m_last_of_item,
    output logic                    m_last_of_frame
);

    // byte sequencer states
    localparam logic [2:0] ST_ADDR = 3'd0;
    localparam logic [2:0] ST_LEN  = 3'd1;
    localparam logic [2:0] ST_TYPE = 3'd2;
    localparam logic [2:0] ST_DATA = 3'd3;
    localparam logic [2:0] ST_PART = 3'd4;
    localparam logic [2:0] ST_ARM  = 3'd5;
    localparam logic [2:0] ST_CRC  = 3'd6;

    // configuration registers
    logic        sw_arm_reg;
    logic [7:0]  dev_addr_reg;
    logic [7:0]  frame_type_reg;
    logic [7:0]  crc_poly_reg;

    // input stage
    logic                     in_valid_reg, in_valid_next;
    logic [CHANNEL_BITS-1:0]  in_val_reg;
    logic [CHANNEL_BITS-1:0]  scaled;

    // sequencer state
    logic                     active_reg, active_next;
    logic [2:0]               state_reg, state_next;
    logic [2:0]               state_next_sel;
    logic                     item_last_reg, item_last_next;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic [HELD_W-1:0]        held_reg, held_next;
    logic [7:0]               crc_reg, crc_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;

    // output register
    logic                     m_valid_reg, m_valid_next;
    logic [7:0]               m_byte_reg, m_byte_next;
    logic                     m_loi_reg, m_loi_next;
    logic                     m_lof_reg, m_lof_next;

    // per-cycle decode
    logic                     emit;
    logic                     load;
    logic [7:0]               byte_sel;
    logic                     covered;
    logic                     item_done;
    logic                     frame_done;
    logic [HELD_W-1:0]        held_dec;

    rcfp_scale u_scale (
        .channel_value (s_channel_value),
        .scaled        (scaled)
    );

    // configuration port, no read-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_arm_reg     <= 1'b0;
            dev_addr_reg   <= 8'd238;
            frame_type_reg <= 8'd22;
            crc_poly_reg   <= 8'd213;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_SWITCH_ARMING:  sw_arm_reg     <= cfg_data[0];
                CFG_DEVICE_ADDRESS: dev_addr_reg   <= cfg_data;
                CFG_FRAME_TYPE:     frame_type_reg <= cfg_data;
                CFG_CRC_POLYNOMIAL: crc_poly_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // a byte leaves whenever the output register is free or being drained
    assign emit     = active_reg && (!m_valid_reg || m_ready);
    assign held_dec = held_reg - HELD_W'(8);

    // byte selection for the current sequencer state
    always_comb begin
        byte_sel   = 8'd0;
        covered    = 1'b0;
        item_done  = 1'b0;
        frame_done = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_ADDR: begin
                byte_sel   = dev_addr_reg;
                state_next = ST_LEN;
            end
            ST_LEN: begin
                byte_sel   = LEN_BASE + 8'(sw_arm_reg);
                state_next = ST_TYPE;
            end
            ST_TYPE: begin
                byte_sel   = frame_type_reg;
                covered    = 1'b1;
                state_next = ST_DATA;
            end
            ST_DATA: begin
                byte_sel = acc_reg[7:0];
                covered  = 1'b1;
                // stay while a full byte remains, else wrap up the item
                if (held_dec >= HELD_W'(8)) begin
                    state_next = ST_DATA;
                end else if (!item_last_reg) begin
                    item_done  = 1'b1;
                end else if (held_dec != '0) begin
                    state_next = ST_PART;
                end else if (sw_arm_reg) begin
                    state_next = ST_ARM;
                end else begin
                    state_next = ST_CRC;
                end
            end
            ST_PART: begin
                byte_sel   = acc_reg[7:0];
                covered    = 1'b1;
                state_next = sw_arm_reg ? ST_ARM : ST_CRC;
            end
            ST_ARM: begin
                byte_sel   = 8'd1;
                covered    = 1'b1;
                state_next = ST_CRC;
            end
            ST_CRC: begin
                byte_sel   = crc_reg;
                item_done  = 1'b1;
                frame_done = 1'b1;
            end
            default: begin
                byte_sel = 8'd0;
            end
        endcase
    end

    // next item enters as soon as the current one sends its last byte
    assign load    = in_valid_reg && (!active_reg || (emit && item_done));
    assign s_ready = !in_valid_reg || load;

    always_comb begin
        in_valid_next  = in_valid_reg;
        active_next    = active_reg;
        item_last_next = item_last_reg;
        acc_next       = acc_reg;
        held_next      = held_reg;
        crc_next       = crc_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg;
        m_byte_next    = m_byte_reg;
        m_loi_next     = m_loi_reg;
        m_lof_next     = m_lof_reg;

        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (load) begin
            in_valid_next = 1'b0;
        end

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (emit) begin
            m_valid_next = 1'b1;
            m_byte_next  = byte_sel;
            m_loi_next   = item_done;
            m_lof_next   = frame_done;

            if (state_reg == ST_ADDR) begin
                crc_next = 8'd0;
            end else if (covered) begin
                crc_next = crc8_byte(crc_reg, byte_sel, crc_poly_reg);
            end

            if (state_reg == ST_DATA) begin
                acc_next  = acc_reg >> 8;
                held_next = held_dec;
            end else if (state_reg == ST_PART || frame_done) begin
                acc_next  = '0;
                held_next = '0;
            end

            if (frame_done) begin
                crc_next = 8'd0;
            end

            if (item_done) begin
                active_next = 1'b0;
            end
        end

        // merge the new channel field above the leftover bits
        if (load) begin
            active_next    = 1'b1;
            acc_next       = acc_next | (ACC_W'(in_val_reg) << held_next);
            held_next      = held_next + HELD_W'(CHANNEL_BITS);
            item_last_next = (cnt_reg == CNT_W'(CHANNEL_COUNT - 1));
            cnt_next       = item_last_next ? '0 : cnt_reg + CNT_W'(1);
        end
    end

    always_comb begin
        if (load) begin
            state_next_sel = (cnt_reg == '0) ? ST_ADDR : ST_DATA;
        end else if (emit) begin
            state_next_sel = state_next;
        end else begin
            state_next_sel = state_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            active_reg    <= 1'b0;
            state_reg     <= ST_ADDR;
            item_last_reg <= 1'b0;
            acc_reg       <= '0;
            held_reg      <= '0;
            crc_reg       <= 8'd0;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            active_reg    <= active_next;
            state_reg     <= state_next_sel;
            item_last_reg <= item_last_next;
            acc_reg       <= acc_next;
            held_reg      <= held_next;
            crc_reg       <= crc_next;
            cnt_reg       <= cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_val_reg <= scaled;
        end
        m_byte_reg <= m_byte_next;
        m_loi_reg  <= m_loi_next;
        m_lof_reg  <= m_lof_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_out_byte      = m_byte_reg;
    assign m_last_of_item  = m_loi_reg;
    assign m_last_of_frame = m_lof_reg;

    // the crc byte always closes the item as well
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_of_frame |-> m_last_of_item)
        else $error("frame end without item end");

    // no bits may be left over when the crc goes out
    assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg && state_reg == ST_CRC |-> held_reg == '0)
        else $error("bits pending at crc");

    // the accumulator never holds more bits than it is wide
    assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= HELD_W'(ACC_W))
        else $error("bit count overflow");

    // a stalled input stage always holds an item
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && active_reg)
        else $error("input stalled with nothing pending");

endmodule

/* test/tb_top.sv */
module tb_top;
    import rcfp_pkg::*;

    // scaling and frame constants, kept local to the predictor
    localparam int CENTER      = 992;
    localparam int FULL_SCALE  = 2 * CENTER;
    localparam int FIELD_MAX   = (1 << CHANNEL_BITS) - 1;
    localparam int PAYLOAD_LEN = (CHANNEL_COUNT * CHANNEL_BITS + 7) / 8;
    localparam int DRAIN_WAIT  = 8;
    localparam int RANDOM_ITEMS = 220;
    localparam int LONG_HOLD   = 200;

    // one expected frame byte with its end markers
    typedef struct packed {
        logic [7:0] data;
        logic       item_end;
        logic       frame_end;
    } frame_byte_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_addr  = CFG_SWITCH_ARMING;
    logic [7:0] cfg_data  = 8'h00;

    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic signed [IN_W-1:0] s_channel_value = '0;

    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_last_of_item;
    logic       m_last_of_frame;

    rc_channel_frame_packer i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_channel_value (s_channel_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_last_of_item  (m_last_of_item),
        .m_last_of_frame (m_last_of_frame)
    );

    always #1 aclk = ~aclk;

    // channel values waiting to be offered, and frame bytes waiting to come out
    logic signed [IN_W-1:0] channel_stream_q[$];
    frame_byte_t            frame_bytes_q[$];

    // register copies as the block should hold them
    logic       arm_switch  = 1'b0;
    logic [7:0] dest_addr   = 8'd238;
    logic [7:0] type_byte   = 8'd22;
    logic [7:0] crc_poly    = 8'd213;

    // packer state copy
    logic [31:0] pk_acc  = '0;
    int          pk_held = 0;
    int          pk_chan = 0;
    logic [7:0]  pk_crc  = '0;

    // last byte of the current item is held back so its item_end can be set
    frame_byte_t tail_byte;
    bit          tail_valid = 1'b0;

    int mismatch_count = 0;
    int bytes_seen     = 0;

    // crc-8 msb first, fed one data bit at a time
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ b[i];
            c  = {c[6:0], 1'b0};
            if (fb) c = c ^ crc_poly;
        end
        return c;
    endfunction

    function automatic void emit_byte(input logic [7:0] b, input bit in_crc, input bit eof);
        if (tail_valid) frame_bytes_q.push_back(tail_byte);
        tail_byte.data      = b;
        tail_byte.item_end  = 1'b0;
        tail_byte.frame_end = eof;
        tail_valid          = 1'b1;
        if (in_crc) pk_crc = crc8_next(pk_crc, b);
    endfunction

    // expected bytes for one accepted channel value
    function automatic void pack_channel(input logic signed [IN_W-1:0] v);
        int scaled;
        scaled = CENTER + (int'(v) * 4) / 5;
        if (scaled < 0) scaled = 0;
        if (scaled > FULL_SCALE) scaled = FULL_SCALE;
        if (scaled > FIELD_MAX) scaled = FIELD_MAX;

        // header goes out ahead of the first channel
        if (pk_chan == 0) begin
            pk_acc  = '0;
            pk_held = 0;
            pk_crc  = '0;
            emit_byte(dest_addr, 1'b0, 1'b0);
            emit_byte(8'(2 + PAYLOAD_LEN + int'(arm_switch)), 1'b0, 1'b0);
            emit_byte(type_byte, 1'b1, 1'b0);
        end

        pk_acc  = pk_acc | (32'(scaled) << pk_held);
        pk_held = pk_held + CHANNEL_BITS;
        while (pk_held >= 8) begin
            emit_byte(pk_acc[7:0], 1'b1, 1'b0);
            pk_acc  = pk_acc >> 8;
            pk_held = pk_held - 8;
        end

        // frame tail: padded partial byte, optional armed byte, crc
        if (pk_chan + 1 >= CHANNEL_COUNT) begin
            if (pk_held > 0) emit_byte(pk_acc[7:0], 1'b1, 1'b0);
            if (arm_switch) emit_byte(8'd1, 1'b1, 1'b0);
            emit_byte(pk_crc, 1'b0, 1'b1);
            pk_acc  = '0;
            pk_held = 0;
            pk_chan = 0;
            pk_crc  = '0;
        end else begin
            pk_chan = pk_chan + 1;
        end

        tail_byte.item_end = 1'b1;
        frame_bytes_q.push_back(tail_byte);
        tail_valid = 1'b0;
    endfunction

    // sender: holds each transfer until accepted, then idles a drawn number of cycles
    int src_gap  = 0;
    bit src_busy = 1'b0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                pack_channel(s_channel_value);
                if ($urandom_range(0, 15) == 0) src_busy = !src_busy;
                src_gap = src_busy ? 0 : $urandom_range(0, 13);
            end
            if (s_valid && !s_ready) begin
                // payload stays put until the transfer completes
            end else if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (channel_stream_q.size() != 0) begin
                s_valid         <= 1'b1;
                s_channel_value <= channel_stream_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: checks every byte, stalls at random, and twice holds off for long
    int sink_gap  = 0;
    int sink_hold = 0;
    bit sink_busy = 1'b0;
    always @(posedge aclk) begin
        frame_byte_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                bytes_seen++;
                if (frame_bytes_q.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("byte %0d: unexpected %02h item_end %b frame_end %b",
                                 bytes_seen, m_out_byte, m_last_of_item, m_last_of_frame);
                    mismatch_count++;
                end else begin
                    want = frame_bytes_q.pop_front();
                    if (m_out_byte !== want.data || m_last_of_item !== want.item_end ||
                        m_last_of_frame !== want.frame_end) begin
                        if (mismatch_count < 10)
                            $display("byte %0d: expected %02h/%b/%b got %02h/%b/%b",
                                     bytes_seen, want.data, want.item_end, want.frame_end,
                                     m_out_byte, m_last_of_item, m_last_of_frame);
                        mismatch_count++;
                    end
                end
                // long hold-off so the block backs up into its input
                if (bytes_seen == 4 || bytes_seen == 150) sink_hold = LONG_HOLD;
                if ($urandom_range(0, 15) == 0) sink_busy = !sink_busy;
                sink_gap = sink_busy ? 0 : $urandom_range(0, 13);
            end
            if (sink_hold > 0) begin
                sink_hold--;
                m_ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // register write, only issued while nothing is in flight
    task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_SWITCH_ARMING:  arm_switch = value[0];
            CFG_DEVICE_ADDRESS: dest_addr  = value;
            CFG_FRAME_TYPE:     type_byte  = value;
            CFG_CRC_POLYNOMIAL: crc_poly   = value;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (channel_stream_q.size() != 0 || s_valid || frame_bytes_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    function automatic logic [7:0] draw_reg_value();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // mix of full-range, saturation-edge and nominal values
    function automatic logic signed [IN_W-1:0] draw_channel();
        int mag;
        case ($urandom_range(0, 4))
            0: return IN_W'($urandom_range(0, (1 << IN_W) - 1));
            1: begin
                mag = $urandom_range(1234, 1246);
                return IN_W'($urandom_range(0, 1) ? mag : -mag);
            end
            2: return IN_W'(int'($urandom_range(0, 12)) - 6);
            default: return IN_W'(int'($urandom_range(0, 2048)) - 1024);
        endcase
    endfunction

    // full first frame: range ends, rounding toward zero, both saturation edges
    int edge_values[16] = '{-2048, 2047, -1024, 1024, 0, -1, 1, -4,
                            4, -5, 5, -1240, -1241, -1242, 1240, 1242};
    // second burst stops mid-frame so arming changes between length and tail
    int mid_values[9] = '{0, -2048, 2047, 1241, -1, 512, -512, 1000, -1000};

    initial begin
        int left;
        int chunk;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values in force for the first frame
        @(negedge aclk);
        foreach (edge_values[i]) channel_stream_q.push_back(IN_W'(edge_values[i]));
        wait_drained();

        write_register(CFG_SWITCH_ARMING, 8'd1);
        write_register(CFG_DEVICE_ADDRESS, 8'hFF);
        write_register(CFG_FRAME_TYPE, 8'h00);
        write_register(CFG_CRC_POLYNOMIAL, 8'hFF);
        @(negedge aclk);
        foreach (mid_values[i]) channel_stream_q.push_back(IN_W'(mid_values[i]));
        wait_drained();

        // armed byte dropped at the tail of a frame whose length counted it
        write_register(CFG_SWITCH_ARMING, 8'd0);
        write_register(CFG_CRC_POLYNOMIAL, 8'h07);

        left = RANDOM_ITEMS;
        while (left > 0) begin
            chunk = $urandom_range(10, 60);
            if (chunk > left) chunk = left;
            @(negedge aclk);
            repeat (chunk) channel_stream_q.push_back(draw_channel());
            left -= chunk;
            wait_drained();
            if (left > 0) begin
                if ($urandom_range(0, 1))
                    write_register(CFG_SWITCH_ARMING, 8'($urandom_range(0, 1)));
                if ($urandom_range(0, 1)) write_register(CFG_DEVICE_ADDRESS, draw_reg_value());
                if ($urandom_range(0, 1)) write_register(CFG_FRAME_TYPE, draw_reg_value());
                if ($urandom_range(0, 1)) write_register(CFG_CRC_POLYNOMIAL, draw_reg_value());
            end
        end

        if (mismatch_count == 0) begin
            $display("rc_channel_frame_packer verification clean");
        end else begin
            $display("rc_channel_frame_packer verification failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #1000000;
        $display("rc_channel_frame_packer verification failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/rcfp_pkg.sv
rtl/core/rcfp_scale.sv
rtl/core/rc_channel_frame_packer.sv
test/tb_top.sv
